/* hw/rtl/owm_pkg.sv */
// Types and constants shared by the single-wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

   // Command codes carried in the func field
   localparam logic [1:0] FUNC_NONE  = 2'd0;
   localparam logic [1:0] FUNC_RESET = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] CSR_RESET_TAIL    = 3'd2;
   localparam logic [2:0] CSR_SLOT_LOW      = 3'd3;
   localparam logic [2:0] CSR_READ_SAMPLE   = 3'd4;
   localparam logic [2:0] CSR_READ_TAIL     = 3'd5;
   localparam logic [2:0] CSR_WRITE_HOLD    = 3'd6;

   localparam int unsigned CSR_BITS = 10;

   // Register reset values
   localparam logic [CSR_BITS-1:0] RST_RESET_LOW     = 10'd500;
   localparam logic [CSR_BITS-1:0] RST_PRESENCE_WAIT = 10'd100;
   localparam logic [CSR_BITS-1:0] RST_RESET_TAIL    = 10'd500;
   localparam logic [CSR_BITS-1:0] RST_SLOT_LOW      = 10'd10;
   localparam logic [CSR_BITS-1:0] RST_READ_SAMPLE   = 10'd10;
   localparam logic [CSR_BITS-1:0] RST_READ_TAIL     = 10'd50;
   localparam logic [CSR_BITS-1:0] RST_WRITE_HOLD    = 10'd100;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_RST_TAIL,
      PH_RD_LOW,
      PH_RD_WAIT,
      PH_RD_TAIL,
      PH_WR_LOW,
      PH_WR_HOLD
   } phase_type;

   typedef struct packed {
      logic [CSR_BITS-1:0] reset_low_us;
      logic [CSR_BITS-1:0] presence_wait_us;
      logic [CSR_BITS-1:0] reset_tail_us;
      logic [CSR_BITS-1:0] slot_low_us;
      logic [CSR_BITS-1:0] read_sample_us;
      logic [CSR_BITS-1:0] read_tail_us;
      logic [CSR_BITS-1:0] write_hold_us;
   } cfg_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] tx_byte;
      logic       line_level;
   } req_word_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] rx_byte;
   } rsp_word_type;

endpackage

/* hw/rtl/one_wire_master_unit.sv */
// Top level of the single-wire bus master: tick register, sequencer, result register.
//
// Usage:
//   req channel: one word per microsecond tick (func, tx_byte, line_level).
//     func starts a reset, byte write or byte read when the master is idle;
//     it is ignored while busy. line_level is the sampled bus level.
//   rsp channel: one word per accepted tick (drive_low, busy_res, done_res,
//     presence, rx_byte), in order, reflecting state after that tick.
//   csr port: csr_wen/csr_index/csr_wdata write the seven timing registers;
//     write only while idle. Indexes above six are dropped.
// Path: an accepted tick is held in the tick register, then shows on rsp from
//   the result register (sequencer runs from the tick register straight into it).
// Throughput: one tick per cycle unless rsp stalls; the sequencer update is
//   a single pass of compare/decrement on the slot timer plus the phase decode.
// Stall: when rsp_ready is low the result register holds, the tick register
//   keeps one more word, and req_ready drops once both are full.
// Reset: synchronous; both registers empty, phase idle, line released,
//   timing registers return to their defaults.
`timescale 1ns / 1ps

module one_wire_master_unit #(
   parameter int unsigned TIMER_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  owm_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output owm_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_wen,
   input  logic [2:0]                    csr_index,
   input  logic [owm_pkg::CSR_BITS-1:0]  csr_wdata
);
   import owm_pkg::*;

   cfg_type      cfg;
   req_word_type tick_ff, tick_in;
   logic         tick_valid_ff, tick_valid_in;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type result;
   logic         out_free;
   logic         step;

   // result register can take a word this cycle
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign step      = tick_valid_ff & out_free;
   assign req_ready = ~tick_valid_ff | out_free;

   owm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owm_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .tick_word (tick_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // tick register
   always_comb begin
      tick_in       = tick_ff;
      tick_valid_in = tick_valid_ff & ~step;
      if (req_valid && req_ready) begin
         tick_in       = req_word;
         tick_valid_in = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (step) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // a finishing tick never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.busy_res))
      else $error("done and busy reported together");

   // the line is released whenever the master is idle
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.drive_low || rsp_ff.busy_res))
      else $error("line driven low while idle");

   // a held tick is not dropped while the result side stalls
   a_tick_kept: assert property (@(posedge clock) disable iff (reset)
      (tick_valid_ff && rsp_valid_ff && !rsp_ready) |=> tick_valid_ff)
      else $error("tick word lost during stall");

   // the sequencer only advances when a result is loaded
   a_step_loads: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("sequencer step without result word");

endmodule

/* hw/rtl/owm_csr.sv */
// Timing configuration registers of the single-wire bus master.
`timescale 1ns / 1ps

module owm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [2:0]                    csr_index,
   input  logic [owm_pkg::CSR_BITS-1:0]  csr_wdata,
   output owm_pkg::cfg_type              cfg
);
   import owm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_RESET_LOW:     cfg_in.reset_low_us     = csr_wdata;
            CSR_PRESENCE_WAIT: cfg_in.presence_wait_us = csr_wdata;
            CSR_RESET_TAIL:    cfg_in.reset_tail_us    = csr_wdata;
            CSR_SLOT_LOW:      cfg_in.slot_low_us      = csr_wdata;
            CSR_READ_SAMPLE:   cfg_in.read_sample_us   = csr_wdata;
            CSR_READ_TAIL:     cfg_in.read_tail_us     = csr_wdata;
            CSR_WRITE_HOLD:    cfg_in.write_hold_us    = csr_wdata;
            default:           cfg_in = cfg_ff;  // unused index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us     <= RST_RESET_LOW;
         cfg_ff.presence_wait_us <= RST_PRESENCE_WAIT;
         cfg_ff.reset_tail_us    <= RST_RESET_TAIL;
         cfg_ff.slot_low_us      <= RST_SLOT_LOW;
         cfg_ff.read_sample_us   <= RST_READ_SAMPLE;
         cfg_ff.read_tail_us     <= RST_READ_TAIL;
         cfg_ff.write_hold_us    <= RST_WRITE_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/owm_ctrl.sv */
// Phase sequencer, slot timer and shift register of the bus master.
`timescale 1ns / 1ps

module owm_ctrl #(
   parameter int unsigned TIMER_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  owm_pkg::req_word_type  tick_word,
   input  owm_pkg::cfg_type       cfg,
   output owm_pkg::rsp_word_type  result
);
   import owm_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] tick_timer_ff, tick_timer_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  presence_ff, presence_in;
   logic                  drive_ff, drive_in;
   logic [7:0]            rx_last_ff, rx_last_in;
   logic                  done;

   // durations masked to the timer width
   logic [TIMER_BITS-1:0] t_reset_low, t_presence_wait, t_reset_tail;
   logic [TIMER_BITS-1:0] t_slot_low, t_read_sample, t_read_tail, t_write_hold;
   logic [3:0]            bit_count_inc;

   assign t_reset_low     = TIMER_BITS'(cfg.reset_low_us);
   assign t_presence_wait = TIMER_BITS'(cfg.presence_wait_us);
   assign t_reset_tail    = TIMER_BITS'(cfg.reset_tail_us);
   assign t_slot_low      = TIMER_BITS'(cfg.slot_low_us);
   assign t_read_sample   = TIMER_BITS'(cfg.read_sample_us);
   assign t_read_tail     = TIMER_BITS'(cfg.read_tail_us);
   assign t_write_hold    = TIMER_BITS'(cfg.write_hold_us);
   assign bit_count_inc   = bit_count_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      tick_timer_in = tick_timer_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      presence_in   = presence_ff;
      drive_in      = drive_ff;
      rx_last_in    = rx_last_ff;
      done          = 1'b0;

      if (phase_ff == PH_IDLE) begin
         unique case (tick_word.func)
            FUNC_RESET: begin
               phase_in      = PH_RST_LOW;
               tick_timer_in = t_reset_low;
               drive_in      = 1'b1;
            end
            FUNC_WRITE: begin
               shift_in      = tick_word.tx_byte;
               bit_count_in  = 4'd0;
               phase_in      = PH_WR_LOW;
               tick_timer_in = t_slot_low;
               drive_in      = 1'b1;
            end
            FUNC_READ: begin
               shift_in      = 8'd0;
               bit_count_in  = 4'd0;
               phase_in      = PH_RD_LOW;
               tick_timer_in = t_slot_low;
               drive_in      = 1'b1;
            end
            default: ;  // no command
         endcase
      end else if (tick_timer_ff > TIMER_BITS'(1)) begin
         tick_timer_in = tick_timer_ff - TIMER_BITS'(1);
      end else begin
         unique case (phase_ff)
            PH_RST_LOW: begin
               phase_in      = PH_RST_WAIT;
               tick_timer_in = t_presence_wait;
               drive_in      = 1'b0;
            end
            PH_RST_WAIT: begin
               presence_in   = ~tick_word.line_level;
               phase_in      = PH_RST_TAIL;
               tick_timer_in = t_reset_tail;
               drive_in      = 1'b0;
            end
            PH_RD_LOW: begin
               phase_in      = PH_RD_WAIT;
               tick_timer_in = t_read_sample;
               drive_in      = 1'b0;
            end
            PH_RD_WAIT: begin
               shift_in      = {tick_word.line_level, shift_ff[7:1]};
               bit_count_in  = bit_count_inc;
               phase_in      = PH_RD_TAIL;
               tick_timer_in = t_read_tail;
               drive_in      = 1'b0;
            end
            PH_RD_TAIL: begin
               if (bit_count_ff >= BYTE_BITS) begin
                  rx_last_in    = shift_ff;
                  phase_in      = PH_IDLE;
                  tick_timer_in = '0;
                  done          = 1'b1;
               end else begin
                  phase_in      = PH_RD_LOW;
                  tick_timer_in = t_slot_low;
                  drive_in      = 1'b1;
               end
            end
            PH_WR_LOW: begin
               // release for a one, hold low for a zero
               phase_in      = PH_WR_HOLD;
               tick_timer_in = t_write_hold;
               drive_in      = ~shift_ff[0];
            end
            PH_WR_HOLD: begin
               shift_in     = {1'b0, shift_ff[7:1]};
               bit_count_in = bit_count_inc;
               if (bit_count_inc >= BYTE_BITS) begin
                  phase_in      = PH_IDLE;
                  tick_timer_in = '0;
                  drive_in      = 1'b0;
                  done          = 1'b1;
               end else begin
                  phase_in      = PH_WR_LOW;
                  tick_timer_in = t_slot_low;
                  drive_in      = 1'b1;
               end
            end
            default: begin  // reset tail and unused codes
               phase_in      = PH_IDLE;
               tick_timer_in = '0;
               drive_in      = 1'b0;
               done          = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_timer_ff <= '0;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         presence_ff   <= 1'b0;
         drive_ff      <= 1'b0;
         rx_last_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tick_timer_ff <= tick_timer_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         presence_ff   <= presence_in;
         drive_ff      <= drive_in;
         rx_last_ff    <= rx_last_in;
      end
   end

   // result reflects the state after this tick
   assign result.drive_low = drive_in;
   assign result.busy_res  = (phase_in != PH_IDLE);
   assign result.done_res  = done;
   assign result.presence  = presence_in;
   assign result.rx_byte   = rx_last_in;

endmodule
